>>> rtl/lifo_store_with_match_update_core_macros.svh
// assertion macros for the lifo store with match update core
// no dependencies; included by the top level only
`ifndef LIFO_STORE_WITH_MATCH_UPDATE_CORE_MACROS_SVH
`define LIFO_STORE_WITH_MATCH_UPDATE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lswm check failed");

// next-cycle implication, disabled during reset
`define LSWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lswm check failed");

`endif

>>> rtl/lswm_pkg.sv
// shared types, constants and helpers for the lifo store with match update core
// no dependencies
package lswm_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int WORD_W      = 32;

    // request codes
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic        [1:0]        req_type;
        logic signed [WORD_W-1:0] word_value;
        logic signed [WORD_W-1:0] match_value;
    } t_in_req;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_count;
    } t_out_res;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic                     upd;
        logic signed [WORD_W-1:0] word_value;
        logic signed [WORD_W-1:0] match_value;
    } t_cell_ctl;

    // low five bits of the fill count, zero-extended when the count is narrower
    function automatic logic [4:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] wide;
        wide = {5'b0, c};
        return wide[4:0];
    endfunction

endpackage

>>> rtl/lswm_cell.sv
// one storage cell of the stack chain: holds a word, shifts with its neighbors
// depends on lswm_pkg
module lswm_cell import lswm_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_occupied,
    input  logic                     i_hit_above,
    input  logic signed [WORD_W-1:0] i_word_prev,
    input  logic signed [WORD_W-1:0] i_word_next,
    output logic signed [WORD_W-1:0] o_word,
    output logic                     o_hit
);

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;
    logic                     w_match;

    assign w_match = i_occupied && (r_word == i_ctl.match_value);
    assign o_hit   = i_hit_above || w_match;
    assign o_word  = r_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.push) begin
            n_word = i_word_prev;
        end else if (i_ctl.pop) begin
            n_word = i_word_next;
        end else if (i_ctl.upd && w_match && !i_hit_above) begin
            // topmost matching word only
            n_word = i_ctl.word_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

>>> rtl/lifo_store_with_match_update_core.sv
// top level of the lifo store with match update core: request handling,
// fill count and result register around a chain of lswm_cell storage cells
// depends on lswm_pkg, lswm_cell and the assertion macro header
//
// usage
//   input channel: i_in_valid / o_in_stall carry one request (push, pop top,
//   update first match, clear all); a request is taken on a rising edge with
//   valid high and stall low
//   output channel: o_out_valid / i_out_stall carry one result per request:
//   status and the word count after the request
//   result: registered, shown in the cycle after the request is taken
//   throughput: one request per cycle while o_in_stall is low; every request
//   finishes in the cycle it is taken, since each cell compares its own word and
//   the topmost hit rides down the chain in the same cycle
//   stall: while a result waits under i_out_stall, o_in_stall is raised, and
//   a new request is taken in the same cycle that the waiting result leaves
//   reset (synchronous, active low): o_in_stall is held high, the store is
//   empty and no result is pending; stored words keep whatever they held and
//   are never read unfilled
`include "lifo_store_with_match_update_core_macros.svh"

module lifo_store_with_match_update_core import lswm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_res
);

    // fill count: cell 0 is the top of the stack
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register between the two channels
    logic     r_out_valid;
    t_out_res r_out;
    t_out_res n_out;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    logic      w_found;
    logic      w_pop_on_empty;
    t_cell_ctl w_ctl;

    logic signed [WORD_W-1:0] w_word [STORE_DEPTH];
    logic                     w_hit  [STORE_DEPTH+1];

    // a new request may enter whenever the result slot is free or draining
    // nothing is taken while reset is low
    assign o_in_stall = !i_rst_n || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = (r_count == CNT_W'(STORE_DEPTH));
    assign w_empty = (r_count == '0);

    // chain control, broadcast to all cells
    always_comb begin
        w_ctl.push        = w_accept && (i_in_req.req_type == REQ_PUSH) && !w_full;
        w_ctl.pop         = w_accept && (i_in_req.req_type == REQ_POP) && !w_empty;
        w_ctl.upd         = w_accept && (i_in_req.req_type == REQ_UPDATE);
        w_ctl.word_value  = i_in_req.word_value;
        w_ctl.match_value = i_in_req.match_value;
    end

    // no cell above the top can hit
    assign w_hit[0] = 1'b0;

    for (genvar gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
        logic signed [WORD_W-1:0] w_prev;
        logic signed [WORD_W-1:0] w_next;
        logic                     w_occ;

        // push feeds the new word into the top cell
        if (gi == 0) begin : g_top
            assign w_prev = i_in_req.word_value;
        end else begin : g_mid
            assign w_prev = w_word[gi-1];
        end

        // the bottom cell has nothing below it to pull up
        if (gi == STORE_DEPTH - 1) begin : g_bottom
            assign w_next = w_word[gi];
        end else begin : g_inner
            assign w_next = w_word[gi+1];
        end

        assign w_occ = (r_count > CNT_W'(gi));

        lswm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (w_occ),
            .i_hit_above (w_hit[gi]),
            .i_word_prev (w_prev),
            .i_word_next (w_next),
            .o_word      (w_word[gi]),
            .o_hit       (w_hit[gi+1])
        );
    end

    // any occupied cell matching the search value
    assign w_found = w_hit[STORE_DEPTH];

    // next count and the result of the request
    always_comb begin
        n_count      = r_count;
        n_out.status = ST_DONE;
        case (i_in_req.req_type)
            REQ_PUSH: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            REQ_UPDATE: begin
                if (!w_found) begin
                    n_out.status = ST_NOT_FOUND;
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.entry_count = count_field(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // pop request taken while the store is empty
    assign w_pop_on_empty = w_accept && (i_in_req.req_type == REQ_POP) && w_empty;

    // checks
    `LSWM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STORE_DEPTH))
    `LSWM_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_ctl.push, r_count == $past(r_count) + 1'b1)
    `LSWM_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, r_out_valid)
    `LSWM_ASSERT_NEXT(a_pop_empty, i_clk, i_rst_n, w_pop_on_empty, r_out.status == ST_EMPTY)

endmodule

>>> test/tb_top.sv
// testbench for lifo_store_with_match_update_core: a shadow stack predicts status and count
// for each request, and the results are checked in order under random gaps and stalls
// depends on lswm_pkg and the core's rtl
module tb_top;
    import lswm_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int RANDOM_REQUESTS  = 1000;
    localparam int BURST_REQUESTS   = 200;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_res o_out_res;

    lifo_store_with_match_update_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    // shadow copy of the stack and the results it predicts, oldest first
    logic [WORD_W-1:0] shadow_words [STORE_DEPTH];
    int                shadow_fill;
    t_out_res          pending_results [$];

    int  fail_count;
    int  results_checked;
    int  cycle_count;
    int  accepted_by_kind [4];
    int  status_seen [4];

    // controls for the request sender and the result receiver
    bit  gaps_on;
    bit  out_stall_on;
    bit  hold_pending;
    bit  hold_active;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // predicted effect of one request on the shadow stack
    function automatic t_out_res apply_to_shadow_stack(input t_in_req req);
        t_out_res res;
        int       k;
        bit       hit;
        res.status = ST_DONE;
        case (req.req_type)
            REQ_PUSH: begin
                if (shadow_fill < STORE_DEPTH) begin
                    shadow_words[shadow_fill] = req.word_value;
                    shadow_fill++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            REQ_POP: begin
                if (shadow_fill > 0) begin
                    shadow_fill--;
                end else begin
                    res.status = ST_EMPTY;
                end
            end
            REQ_UPDATE: begin
                // topmost equal word wins
                hit = 1'b0;
                for (k = shadow_fill - 1; k >= 0 && !hit; k--) begin
                    if (shadow_words[k] == req.match_value) begin
                        shadow_words[k] = req.word_value;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                shadow_fill = 0;
            end
        endcase
        res.entry_count = 5'(shadow_fill);
        return res;
    endfunction

    function automatic t_in_req make_req(input logic [1:0] kind, input logic [31:0] word,
                                         input logic [31:0] match);
        t_in_req req;
        req.req_type    = kind;
        req.word_value  = word;
        req.match_value = match;
        return req;
    endfunction

    // extremes and small values often, so equal words show up in the stack
    function automatic logic [31:0] random_word();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return 32'($signed($urandom_range(0, 6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    // push heavy or pop heavy mix; updates mostly aim at a stored word
    function automatic t_in_req random_request(input bit fill_bias);
        int          pick;
        logic [1:0]  kind;
        logic [31:0] match;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            kind = REQ_CLEAR;
        end else if (pick < (fill_bias ? 53 : 28)) begin
            kind = REQ_PUSH;
        end else if (pick < 68) begin
            kind = REQ_POP;
        end else begin
            kind = REQ_UPDATE;
        end
        if (shadow_fill > 0 && $urandom_range(0, 3) != 0) begin
            match = shadow_words[$urandom_range(0, shadow_fill - 1)];
        end else begin
            match = random_word();
        end
        return make_req(kind, random_word(), match);
    endfunction

    // mostly short, a few long
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    // offer one request and wait until the core takes it
    task automatic send_request(input t_in_req req);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(apply_to_shadow_stack(req));
        accepted_by_kind[req.req_type]++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // sender stays quiet until every predicted result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: status %0d count %0d",
                       o_out_res.status, o_out_res.entry_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (o_out_res.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, o_out_res.status);
                    fail_count++;
                end
                if (o_out_res.entry_count !== want.entry_count) begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           want.entry_count, o_out_res.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // result receiver: random stalls, plus one long hold on request
    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_active  = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_active  = 1'b0;
            end else if (out_stall_on && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat (gap_length() + 1) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // empty store cases, extremes, duplicate words, fill to full and beyond
    task automatic test_directed_cases();
        logic [31:0] fill_words [16];
        int          i;
        gaps_on      = 1'b0;
        out_stall_on = 1'b0;
        fill_words[0] = 32'h8000_0000;
        fill_words[1] = 32'h7FFF_FFFF;
        fill_words[2] = 32'h0000_0000;
        fill_words[3] = 32'hFFFF_FFFF;
        fill_words[4] = 32'h0000_0005;
        fill_words[5] = 32'hFFFF_FFFF;
        fill_words[6] = 32'h0000_0005;
        for (i = 7; i < 16; i++) begin
            fill_words[i] = $urandom;
        end
        // pop, update and clear on an empty store
        send_request(make_req(REQ_POP, 32'h1234_5678, 32'hFFFF_FFFF));
        send_request(make_req(REQ_UPDATE, 32'h0000_0001, 32'h0000_0000));
        send_request(make_req(REQ_CLEAR, 32'hFFFF_FFFF, 32'h8000_0000));
        for (i = 0; i < 16; i++) begin
            send_request(make_req(REQ_PUSH, fill_words[i], $urandom));
        end
        // push onto a full store is dropped
        send_request(make_req(REQ_PUSH, 32'hDEAD_BEEF, 32'h0));
        // minus one stored twice: only the upper copy changes
        send_request(make_req(REQ_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        // most negative word sits at the bottom
        send_request(make_req(REQ_UPDATE, 32'h0000_0000, 32'h8000_0000));
        send_request(make_req(REQ_UPDATE, 32'h1111_1111, 32'h5555_5555));
        send_request(make_req(REQ_POP, $urandom, $urandom));
        send_request(make_req(REQ_CLEAR, $urandom, $urandom));
        wait_drained();
    endtask

    // long random mix with gaps and stalls on both sides
    task automatic test_random_mix();
        int n;
        int run_left;
        bit fill_bias;
        gaps_on      = 1'b1;
        out_stall_on = 1'b1;
        fill_bias    = 1'b1;
        run_left     = $urandom_range(20, 60);
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (run_left == 0) begin
                fill_bias = !fill_bias;
                run_left  = $urandom_range(20, 60);
            end
            run_left--;
            send_request(random_request(fill_bias));
            if (gaps_on) begin
                pause_sender(gap_length());
            end
        end
        wait_drained();
    endtask

    // back to back requests with the receiver always ready
    task automatic test_full_rate();
        int n;
        gaps_on      = 1'b0;
        out_stall_on = 1'b0;
        for (n = 0; n < BURST_REQUESTS; n++) begin
            send_request(random_request(n % 64 < 32));
        end
        wait_drained();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_hold();
        int n;
        out_stall_on = 1'b1;
        hold_pending = 1'b1;
        while (hold_pending || hold_active) begin
            send_request(random_request(1'b1));
        end
        for (n = 0; n < 30; n++) begin
            send_request(random_request(1'b0));
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_req     <= '0;
        shadow_fill  = 0;
        fail_count   = 0;
        cycle_count  = 0;
        hold_pending = 1'b0;
        hold_active  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_mix();
        test_full_rate();
        test_output_hold();

        // wait before the summary so stray results can still show
        repeat (5) @(posedge i_clk);
        $display("requests: %0d push, %0d pop, %0d update, %0d clear; %0d results checked",
                 accepted_by_kind[REQ_PUSH], accepted_by_kind[REQ_POP],
                 accepted_by_kind[REQ_UPDATE], accepted_by_kind[REQ_CLEAR], results_checked);
        $display("statuses: %0d done, %0d not found, %0d full, %0d empty",
                 status_seen[ST_DONE], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], status_seen[ST_EMPTY]);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
